// ===== hw/rtl/hne_pkg.sv =====
// Shared types and constants of the Hamming neighbor enumerator.
package hne_pkg;

  localparam int unsigned CFG_W    = 5;   // width of each configuration register
  localparam int unsigned CENTER_W = 16;  // width of the center word and of a neighbor
  localparam int unsigned DIST_W   = 5;   // width of the reported distance

  localparam logic [0:0] REG_WORD_LENGTH  = 1'd0;
  localparam logic [0:0] REG_MIN_DISTANCE = 1'd1;

  localparam logic ACT_LOAD = 1'b0;  // load center, return first neighbor
  localparam logic ACT_NEXT = 1'b1;  // return following neighbor

  typedef struct packed {
    logic [CENTER_W-1:0] neighbor;
    logic [DIST_W-1:0]   distance;
    logic                valid_res;
    logic                last;
  } res_t;

endpackage

// ===== hw/rtl/hamming_neighbor_enumerator.sv =====
// Top level of the Hamming neighbor enumerator: input stage, state and result stage.
//
//  channel  | direction | content
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: center_word; tuser: action
//  m_axis   | out       | tdata: neighbor, distance; tuser: valid_res; tlast: last
//  cfg      | in        | write enable, register index, 5-bit data
//
// Each transfer is held in the input register and then passes through the step
// logic, which writes the enumeration state and the result register together.
// One item per cycle is sustained while m_axis is ready; the step unit's state loop sets it.
// Reset clears the state and sets word_length to 12 and min_distance to 2.
// A stalled result holds its register and stops the input stage behind it.
module hamming_neighbor_enumerator import hne_pkg::*; #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] center_word
  input  logic                s_axis_tuser,   // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [15:0] neighbor, [20:16] distance, zero fill
  output logic                m_axis_tuser,   // [0] valid_res
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  logic [CFG_W-1:0]     word_len_q;
  logic [CFG_W-1:0]     min_dist_q;
  logic                 in_valid_q;
  logic                 in_action_q;
  logic [CENTER_W-1:0]  in_center_q;
  logic [WORD_BITS-1:0] center_q, center_d;
  logic [WORD_BITS-1:0] mask_q, mask_d;
  logic [CFG_W-1:0]     weight_q, weight_d;
  logic                 active_q, active_d;
  logic                 out_valid_q;
  res_t                 out_res_q;
  res_t                 res_d;
  logic                 step_go;

  assign step_go       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q <= CFG_W'(12);
      min_dist_q <= CFG_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WORD_LENGTH:  word_len_q <= cfg_wdata_i;
        REG_MIN_DISTANCE: min_dist_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser;
      in_center_q <= s_axis_tdata;
    end
  end

  hne_step #(
    .WORD_BITS(WORD_BITS)
  ) u_step (
    .word_len_i (word_len_q),
    .min_dist_i (min_dist_q),
    .action_i   (in_action_q),
    .center_i   (in_center_q),
    .center_q_i (center_q),
    .mask_q_i   (mask_q),
    .weight_q_i (weight_q),
    .active_q_i (active_q),
    .center_d_o (center_d),
    .mask_d_o   (mask_d),
    .weight_d_o (weight_d),
    .active_d_o (active_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      mask_q   <= '0;
      weight_q <= '0;
      active_q <= 1'b0;
    end else if (step_go) begin
      center_q <= center_d;
      mask_q   <= mask_d;
      weight_q <= weight_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.distance, out_res_q.neighbor};
  assign m_axis_tuser  = out_res_q.valid_res;
  assign m_axis_tlast  = out_res_q.last;

endmodule

// ===== hw/rtl/hne_step.sv =====
// One enumeration step: load or advance the flip mask and form the result.
module hne_step import hne_pkg::*; #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic [CFG_W-1:0]     word_len_i,
  input  logic [CFG_W-1:0]     min_dist_i,
  input  logic                 action_i,
  input  logic [CENTER_W-1:0]  center_i,
  input  logic [WORD_BITS-1:0] center_q_i,
  input  logic [WORD_BITS-1:0] mask_q_i,
  input  logic [CFG_W-1:0]     weight_q_i,
  input  logic                 active_q_i,
  output logic [WORD_BITS-1:0] center_d_o,
  output logic [WORD_BITS-1:0] mask_d_o,
  output logic [CFG_W-1:0]     weight_d_o,
  output logic                 active_d_o,
  output res_t                 res_o
);

  localparam int unsigned MW = WORD_BITS + 1;

  function automatic logic [WORD_BITS-1:0] ones_f(input logic [CFG_W-1:0] n);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = (CFG_W'(i) < n);
    end
    return r;
  endfunction

  logic [CFG_W-1:0]              len;
  logic [WORD_BITS-1:0]          len_mask;
  logic [WORD_BITS+CENTER_W-1:0] center_ext;
  logic [WORD_BITS+CENTER_W-1:0] nb_ext;
  logic [WORD_BITS-1:0]          center_w;
  logic [WORD_BITS-1:0]          mask_w;
  logic [CFG_W-1:0]              weight_w;
  logic                          active_w;
  logic [MW-1:0]                 m_ext;
  logic [MW-1:0]                 t_val;
  logic [MW-1:0]                 t_inc;
  logic [MW-1:0]                 low_bit;
  logic [MW-1:0]                 nxt;
  logic [CFG_W-1:0]              ctz;
  logic [CFG_W:0]                weight_inc;

  always_comb begin
    if (word_len_i == '0) begin
      len = CFG_W'(1);
    end else if (word_len_i > CFG_W'(WORD_BITS)) begin
      len = CFG_W'(WORD_BITS);
    end else begin
      len = word_len_i;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      len_mask[i] = (CFG_W'(i) < len);
    end
  end

  assign center_ext = {{WORD_BITS{1'b0}}, center_i};

  // Gosper step on the working mask; the mask is nonzero whenever the weight is.
  always_comb begin
    ctz = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (mask_w[i]) begin
        ctz = CFG_W'(i);
      end
    end
    m_ext   = {1'b0, mask_w};
    t_val   = m_ext | (m_ext - MW'(1));
    t_inc   = t_val + MW'(1);
    low_bit = t_inc & ~t_val;
    nxt     = t_inc | ((low_bit - MW'(1)) >> (ctz + CFG_W'(1)));
  end

  assign weight_inc = {1'b0, weight_w} + (CFG_W+1)'(1);
  assign nb_ext     = {{CENTER_W{1'b0}}, center_w ^ mask_w};

  always_comb begin
    center_w = center_q_i;
    mask_w   = mask_q_i;
    weight_w = weight_q_i;
    active_w = active_q_i;
    if (action_i == ACT_LOAD) begin
      center_w = center_ext[WORD_BITS-1:0] & len_mask;
      if (min_dist_i > len) begin
        active_w = 1'b0;
        mask_w   = '0;
        weight_w = '0;
      end else begin
        active_w = 1'b1;
        mask_w   = ones_f(min_dist_i);
        weight_w = min_dist_i;
      end
    end

    center_d_o = center_w;
    mask_d_o   = mask_w;
    weight_d_o = weight_w;
    active_d_o = active_w;
    res_o      = '0;

    if (active_w) begin
      if (weight_w > len || (mask_w & ~len_mask) != '0) begin
        // A shorter word length left the pending mask out of range.
        active_d_o = 1'b0;
        mask_d_o   = '0;
        weight_d_o = '0;
      end else begin
        res_o.neighbor  = nb_ext[CENTER_W-1:0];
        res_o.distance  = DIST_W'(weight_w);
        res_o.valid_res = 1'b1;
        if (weight_w == '0) begin
          weight_d_o = CFG_W'(1);
          mask_d_o   = WORD_BITS'(1);
        end else if ((nxt & ~{1'b0, len_mask}) == '0) begin
          mask_d_o = nxt[WORD_BITS-1:0];
        end else if (weight_inc > {1'b0, len}) begin
          active_d_o = 1'b0;
          mask_d_o   = '0;
          weight_d_o = '0;
        end else begin
          weight_d_o = weight_inc[CFG_W-1:0];
          mask_d_o   = ones_f(weight_inc[CFG_W-1:0]);
        end
        res_o.last = ~active_d_o;
      end
    end
  end

endmodule
